FILE: src/uim_pkg.sv
// Package for the union-find item merger.
// Holds the fixed field widths, opcode codes and the sequencer state type.
// No dependencies.
package uim_pkg;

  localparam int OP_W        = 3;
  localparam int ITEM_W      = 8;
  localparam int WEIGHT_W    = 32;
  localparam int TOTAL_W     = 48;
  localparam int COUNT_W     = 9;
  localparam int LABEL_SLOTS = 256;

  localparam logic [COUNT_W-1:0] ITEM_COUNT_RST = 9'd256;

  localparam logic [OP_W-1:0] OP_UNION  = 3'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd1;
  localparam logic [OP_W-1:0] OP_ASSIGN = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_LINK1,
    S_LINK2,
    S_LABEL,
    S_SUMWR,
    S_RDOUT,
    S_PUSH
  } state_t;

endpackage

FILE: src/uim_in_if.sv
// Request channel of the union-find item merger.
// Depends on uim_pkg for field widths.
interface uim_in_if;
  import uim_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ITEM_W-1:0]   first_item;
  logic [ITEM_W-1:0]   second_item;
  logic [WEIGHT_W-1:0] mean_weight;
  logic [WEIGHT_W-1:0] var_weight;

  modport source (output valid, opcode, first_item, second_item, mean_weight, var_weight,
                  input ready);
  modport sink   (input valid, opcode, first_item, second_item, mean_weight, var_weight,
                  output ready);
endinterface

FILE: src/uim_out_if.sv
// Result channel of the union-find item merger.
// Depends on uim_pkg for field widths.
interface uim_out_if;
  import uim_pkg::*;
  logic               valid;
  logic               ready;
  logic [ITEM_W-1:0]  group_label;
  logic [ITEM_W-1:0]  root_item;
  logic               same_set;
  logic [TOTAL_W-1:0] mean_total;
  logic [TOTAL_W-1:0] var_total;
  logic [COUNT_W-1:0] group_count;
  logic               status;

  modport source (output valid, group_label, root_item, same_set, mean_total, var_total,
                  group_count, status, input ready);
  modport sink   (input valid, group_label, root_item, same_set, mean_total, var_total,
                  group_count, status, output ready);
endinterface

FILE: src/uim_cfg_if.sv
// Configuration write channel of the union-find item merger (item_count).
// Depends on uim_pkg for the register width.
interface uim_cfg_if;
  import uim_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] item_count;

  modport source (output valid, item_count, input ready);
  modport sink   (input valid, item_count, output ready);
endinterface

FILE: src/union_find_item_merger.sv
// Union-find item merger: disjoint-set forest with union by size, path compression,
// dense group labels and saturating Q32.16 group totals.
// Depends on uim_pkg, uim_in_if, uim_out_if and uim_cfg_if.
//
// One request word is taken at a time; in_chan.ready is high only while idle. The node
// table is a memory with one write and one registered read port, so a find walks one
// parent pointer per cycle and path compression rewrites one node per cycle. A union that
// links two sets writes both roots in S_LINK1 and S_LINK2. After reset, and for a clear
// request, the node table is swept one entry per cycle, during which no request is taken;
// a clear then pushes its result (configuration writes are always taken). The finished
// result sits in an output register, so the next request is taken while it waits.
module union_find_item_merger #(
  parameter int MAX_ITEMS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  uim_in_if.sink    in_chan,
  uim_out_if.source out_chan,
  uim_cfg_if.sink   cfg_chan
);
  import uim_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int SW = $clog2(MAX_ITEMS + 1);
  localparam int CW = (SW > COUNT_W) ? SW : COUNT_W;
  localparam logic [IW-1:0] CNT_LAST = IW'(MAX_ITEMS - 1);

  typedef struct packed {
    logic              labelled;
    logic [ITEM_W-1:0] label;
    logic [SW-1:0]     size;
    logic [IW-1:0]     parent;
  } node_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] mean;
    logic [TOTAL_W-1:0] vari;
  } sums_t;

  function automatic logic [IW-1:0] to_idx(input logic [ITEM_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[IW-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                 input logic [WEIGHT_W-1:0] w);
    logic [TOTAL_W:0] s;
    s = {1'b0, acc} + (TOTAL_W + 1)'(w);
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

  // memories
  node_t node_mem [MAX_ITEMS];
  sums_t sum_mem  [LABEL_SLOTS];
  node_t node_rd_r;
  sums_t sum_rd_r;
  logic               node_we, sum_we;
  logic [IW-1:0]      node_waddr, node_raddr;
  node_t              node_wdata;
  logic [ITEM_W-1:0]  sum_waddr, sum_raddr;
  sums_t              sum_wdata;

  // control state
  state_t             state_r, state_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic               sweep_push_r, sweep_push_nxt;
  logic [COUNT_W-1:0] next_label_r, next_label_nxt;
  logic [COUNT_W-1:0] item_count_r, item_count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [ITEM_W-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [WEIGHT_W-1:0] mw_r, mw_nxt, vw_r, vw_nxt;
  logic [IW-1:0]       cur_r, cur_nxt, start_r, start_nxt;
  logic [IW-1:0]       root_r, root_nxt, ra_r, ra_nxt;
  node_t               ra_word_r, ra_word_nxt, rb_word_r, rb_word_nxt;
  logic                phase_r, phase_nxt;
  logic [ITEM_W-1:0]   g_r, g_nxt;
  logic                new_r, new_nxt;

  // result registers
  logic [ITEM_W-1:0]  res_label_r, res_label_nxt;
  logic [IW-1:0]      res_root_r, res_root_nxt;
  logic               res_same_r, res_same_nxt;
  logic [TOTAL_W-1:0] res_mt_r, res_mt_nxt, res_vt_r, res_vt_nxt;
  logic               res_status_r, res_status_nxt;

  // output registers
  logic [ITEM_W-1:0]  out_label_r, out_label_nxt;
  logic [ITEM_W-1:0]  out_root_r, out_root_nxt;
  logic               out_same_r, out_same_nxt;
  logic [TOTAL_W-1:0] out_mt_r, out_mt_nxt, out_vt_r, out_vt_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_status_r, out_status_nxt;

  logic          in_fire, out_free;
  logic [CW-1:0] lim, ic_ext;
  logic          a_ok, b_ok, label_ok, label_full, a_big, at_root;
  logic [CW-1:0] root_ext;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign ic_ext     = CW'(item_count_r);
  assign lim        = (ic_ext > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : ic_ext;
  assign a_ok       = CW'(in_chan.first_item) < lim;
  assign b_ok       = CW'(in_chan.second_item) < lim;
  assign label_ok   = COUNT_W'(in_chan.first_item) < next_label_r;
  assign label_full = next_label_r == COUNT_W'(LABEL_SLOTS);
  assign a_big      = ra_word_r.size > rb_word_r.size;
  assign at_root    = cur_r == root_r;
  assign root_ext   = CW'(res_root_r);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.group_label = out_label_r;
  assign out_chan.root_item   = out_root_r;
  assign out_chan.same_set    = out_same_r;
  assign out_chan.mean_total  = out_mt_r;
  assign out_chan.var_total   = out_vt_r;
  assign out_chan.group_count = out_count_r;
  assign out_chan.status      = out_status_r;

  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      S_SWEEP: begin
        if (cnt_r == CNT_LAST) state_nxt = sweep_push_r ? S_PUSH : S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.opcode)
            OP_UNION, OP_QUERY: state_nxt = (a_ok && b_ok) ? S_FIND : S_PUSH;
            OP_ASSIGN:          state_nxt = a_ok ? S_FIND : S_PUSH;
            OP_READ:            state_nxt = label_ok ? S_RDOUT : S_PUSH;
            OP_CLEAR:           state_nxt = S_SWEEP;
            default:            state_nxt = S_PUSH;
          endcase
        end
      end
      S_FIND: begin
        if (node_rd_r.parent == cur_r) state_nxt = S_COMP;
      end
      S_COMP: begin
        if (at_root) begin
          if (!phase_r) state_nxt = (op_r == OP_ASSIGN) ? S_LABEL : S_FIND;
          else state_nxt = (op_r == OP_UNION && root_r != ra_r) ? S_LINK1 : S_PUSH;
        end
      end
      S_LINK1: state_nxt = S_LINK2;
      S_LINK2: state_nxt = S_PUSH;
      S_LABEL: state_nxt = (!ra_word_r.labelled && label_full) ? S_PUSH : S_SUMWR;
      S_SUMWR: state_nxt = S_PUSH;
      S_RDOUT: state_nxt = S_PUSH;
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin : datapath
    cnt_nxt        = cnt_r;
    sweep_push_nxt = sweep_push_r;
    next_label_nxt = next_label_r;
    item_count_nxt = (cfg_chan.valid && cfg_chan.ready) ? cfg_chan.item_count : item_count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    op_nxt = op_r;  a_nxt = a_r;  b_nxt = b_r;  mw_nxt = mw_r;  vw_nxt = vw_r;
    cur_nxt = cur_r;  start_nxt = start_r;  root_nxt = root_r;  ra_nxt = ra_r;
    ra_word_nxt = ra_word_r;  rb_word_nxt = rb_word_r;  phase_nxt = phase_r;
    g_nxt = g_r;  new_nxt = new_r;
    res_label_nxt = res_label_r;  res_root_nxt = res_root_r;  res_same_nxt = res_same_r;
    res_mt_nxt = res_mt_r;  res_vt_nxt = res_vt_r;  res_status_nxt = res_status_r;
    out_label_nxt = out_label_r;  out_root_nxt = out_root_r;  out_same_nxt = out_same_r;
    out_mt_nxt = out_mt_r;  out_vt_nxt = out_vt_r;  out_count_nxt = out_count_r;
    out_status_nxt = out_status_r;
    node_we = 1'b0;  node_waddr = cur_r;  node_wdata = node_rd_r;  node_raddr = cur_r;
    sum_we = 1'b0;  sum_waddr = g_r;  sum_wdata = sum_rd_r;  sum_raddr = g_r;

    case (state_r)
      S_SWEEP: begin
        node_we    = 1'b1;
        node_waddr = cnt_r;
        node_wdata = '{labelled: 1'b0, label: '0, size: SW'(1), parent: cnt_r};
        cnt_nxt    = cnt_r + IW'(1);
        if (cnt_r == CNT_LAST) sweep_push_nxt = 1'b0;
      end
      S_IDLE: begin
        node_raddr = to_idx(in_chan.first_item);
        sum_raddr  = in_chan.first_item;
        if (in_fire) begin
          op_nxt = in_chan.opcode;  a_nxt = in_chan.first_item;  b_nxt = in_chan.second_item;
          mw_nxt = in_chan.mean_weight;  vw_nxt = in_chan.var_weight;
          cur_nxt = to_idx(in_chan.first_item);  start_nxt = to_idx(in_chan.first_item);
          phase_nxt = 1'b0;
          res_label_nxt = '0;  res_root_nxt = '0;  res_same_nxt = 1'b0;
          res_mt_nxt = '0;  res_vt_nxt = '0;  res_status_nxt = 1'b0;
          case (in_chan.opcode)
            OP_UNION, OP_QUERY: res_status_nxt = !(a_ok && b_ok);
            OP_ASSIGN:          res_status_nxt = !a_ok;
            OP_READ:            res_status_nxt = !label_ok;
            OP_CLEAR: begin
              next_label_nxt = '0;
              cnt_nxt        = '0;
              sweep_push_nxt = 1'b1;
            end
            default:            res_status_nxt = 1'b1;
          endcase
        end
      end
      S_FIND: begin
        if (node_rd_r.parent == cur_r) begin
          root_nxt   = cur_r;
          cur_nxt    = start_r;
          node_raddr = start_r;
        end else begin
          cur_nxt    = node_rd_r.parent;
          node_raddr = node_rd_r.parent;
        end
      end
      S_COMP: begin
        if (at_root) begin
          if (!phase_r) begin
            ra_nxt      = root_r;
            ra_word_nxt = node_rd_r;
            phase_nxt   = 1'b1;
            cur_nxt     = to_idx(b_r);
            start_nxt   = to_idx(b_r);
            node_raddr  = to_idx(b_r);
          end else begin
            rb_word_nxt  = node_rd_r;
            res_root_nxt = ra_r;
            res_same_nxt = (root_r == ra_r);
          end
        end else begin
          node_we           = 1'b1;
          node_waddr        = cur_r;
          node_wdata        = node_rd_r;
          node_wdata.parent = root_r;
          cur_nxt           = node_rd_r.parent;
          node_raddr        = node_rd_r.parent;
        end
      end
      S_LINK1: begin
        node_we = 1'b1;
        if (a_big) begin
          node_waddr        = root_r;
          node_wdata        = rb_word_r;
          node_wdata.parent = ra_r;
        end else begin
          node_waddr        = ra_r;
          node_wdata        = ra_word_r;
          node_wdata.parent = root_r;
        end
      end
      S_LINK2: begin
        node_we         = 1'b1;
        node_waddr      = a_big ? ra_r : root_r;
        node_wdata      = a_big ? ra_word_r : rb_word_r;
        node_wdata.size = ra_word_r.size + rb_word_r.size;
        res_root_nxt    = a_big ? ra_r : root_r;
        res_same_nxt    = 1'b1;
      end
      S_LABEL: begin
        if (!ra_word_r.labelled && label_full) begin
          res_status_nxt = 1'b1;
        end else if (!ra_word_r.labelled) begin
          node_we             = 1'b1;
          node_waddr          = ra_r;
          node_wdata          = ra_word_r;
          node_wdata.labelled = 1'b1;
          node_wdata.label    = next_label_r[ITEM_W-1:0];
          g_nxt               = next_label_r[ITEM_W-1:0];
          sum_raddr           = next_label_r[ITEM_W-1:0];
          new_nxt             = 1'b1;
          next_label_nxt      = next_label_r + COUNT_W'(1);
        end else begin
          g_nxt     = ra_word_r.label;
          sum_raddr = ra_word_r.label;
          new_nxt   = 1'b0;
        end
      end
      S_SUMWR: begin
        sum_we         = 1'b1;
        sum_waddr      = g_r;
        sum_wdata.mean = sat_add(new_r ? '0 : sum_rd_r.mean, mw_r);
        sum_wdata.vari = sat_add(new_r ? '0 : sum_rd_r.vari, vw_r);
        res_mt_nxt     = sum_wdata.mean;
        res_vt_nxt     = sum_wdata.vari;
        res_label_nxt  = g_r;
        res_root_nxt   = ra_r;
      end
      S_RDOUT: begin
        res_label_nxt = a_r;
        res_mt_nxt    = sum_rd_r.mean;
        res_vt_nxt    = sum_rd_r.vari;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_label_nxt  = res_label_r;
          out_root_nxt   = root_ext[ITEM_W-1:0];
          out_same_nxt   = res_same_r;
          out_mt_nxt     = res_mt_r;
          out_vt_nxt     = res_vt_r;
          out_count_nxt  = next_label_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd_r <= node_mem[node_raddr];
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      cnt_r        <= '0;
      sweep_push_r <= 1'b0;
      next_label_r <= '0;
      item_count_r <= ITEM_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      sweep_push_r <= sweep_push_nxt;
      next_label_r <= next_label_nxt;
      item_count_r <= item_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  mw_r <= mw_nxt;  vw_r <= vw_nxt;
    cur_r <= cur_nxt;  start_r <= start_nxt;  root_r <= root_nxt;  ra_r <= ra_nxt;
    ra_word_r <= ra_word_nxt;  rb_word_r <= rb_word_nxt;  phase_r <= phase_nxt;
    g_r <= g_nxt;  new_r <= new_nxt;
    res_label_r <= res_label_nxt;  res_root_r <= res_root_nxt;  res_same_r <= res_same_nxt;
    res_mt_r <= res_mt_nxt;  res_vt_r <= res_vt_nxt;  res_status_r <= res_status_nxt;
    out_label_r <= out_label_nxt;  out_root_r <= out_root_nxt;  out_same_r <= out_same_nxt;
    out_mt_r <= out_mt_nxt;  out_vt_r <= out_vt_nxt;  out_count_r <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
